// ===== src/power_mode_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// Power mode scheduler assertion macros
// Shared property forms for the scheduler checks, clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POWER_MODE_SCHEDULER_DEFINES_SVH
`define POWER_MODE_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pms_pkg.sv =====
// ---------------------------------------------------------------------------
// Power mode scheduler package
// Codes, item types, configuration record and mode tables shared by the
// scheduler modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    // Journal geometry
    localparam int JOURNAL_DEPTH = 16;
    localparam int JRN_IW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
    localparam int JRN_FW = $clog2(JOURNAL_DEPTH + 1);
    localparam int JRN_SW = JRN_IW + 1;

    // Modes
    localparam logic [2:0] MODE_SLEEP    = 3'd0;
    localparam logic [2:0] MODE_LISTEN   = 3'd1;
    localparam logic [2:0] MODE_DSP      = 3'd2;
    localparam logic [2:0] MODE_COMMS    = 3'd3;
    localparam logic [2:0] MODE_SERVICE  = 3'd4;
    localparam logic [2:0] MODE_SHUTDOWN = 3'd5;

    // Actions
    localparam logic [1:0] ACT_EVENT   = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    // Events
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_BATT_CRIT  = 4'd1;
    localparam logic [3:0] EV_FAULT      = 4'd2;
    localparam logic [3:0] EV_SVC_BTN    = 4'd3;
    localparam logic [3:0] EV_OUTBOX     = 4'd4;
    localparam logic [3:0] EV_BOOT       = 4'd5;
    localparam logic [3:0] EV_MIC        = 4'd6;
    localparam logic [3:0] EV_GATE_POS   = 4'd7;
    localparam logic [3:0] EV_GATE_NEG   = 4'd8;
    localparam logic [3:0] EV_DSP_EVT    = 4'd9;
    localparam logic [3:0] EV_DSP_NONE   = 4'd10;
    localparam logic [3:0] EV_COMMS_DONE = 4'd11;
    localparam logic [3:0] EV_SVC_EXIT   = 4'd12;

    // Fault codes
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_EXT     = 2'd1;
    localparam logic [1:0] FAULT_OVERRUN = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_DWELL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DSP_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMS_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SVC_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_COMMS   = 3'd6;

    // Configuration reset values
    localparam logic [31:0] RST_LISTEN_DWELL = 32'd3000;
    localparam logic [31:0] RST_DSP_LIMIT    = 32'd20000;
    localparam logic [31:0] RST_COMMS_LIMIT  = 32'd180000;
    localparam logic [31:0] RST_HEARTBEAT    = 32'd21600000;
    localparam logic [31:0] RST_SVC_WINDOW   = 32'd600000;
    localparam logic [31:0] RST_MIN_SLEEP    = 32'd2000;
    localparam logic        RST_BOOT_COMMS   = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  event_code;
        logic [31:0] now_time;
        logic [7:0]  read_keep;
        logic [7:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic        changed;
        logic [2:0]  mode_now;
        logic [5:0]  rails;
        logic [2:0]  clock_profile;
        logic [1:0]  fault_status;
        logic        read_valid;
        logic [31:0] entry_time;
        logic [2:0]  entry_from;
        logic [2:0]  entry_to;
        logic [3:0]  entry_event;
        logic [7:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] listen_dwell;
        logic [31:0] dsp_limit;
        logic [31:0] comms_limit;
        logic [31:0] heartbeat_period;
        logic [31:0] service_window;
        logic [31:0] min_sleep;
        logic        boot_comms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] stamp;
        logic [2:0]  from_mode;
        logic [2:0]  to_mode;
        logic [3:0]  cause;
    } t_jrn_rec;

    typedef struct packed {
        logic     en;
        t_jrn_rec rec;
    } t_jrn_wr;

    typedef struct packed {
        logic       changed;
        logic [2:0] mode;
        logic [1:0] fault;
    } t_ctrl_status;

    // Rail enables per mode: mic, filter clock, gnss, modem, ble, deep-stop.
    function automatic logic [5:0] mode_rails(input logic [2:0] mode);
        logic [5:0] rails;
        case (mode)
            MODE_SLEEP:   rails = 6'd33;
            MODE_LISTEN:  rails = 6'd7;
            MODE_DSP:     rails = 6'd7;
            MODE_COMMS:   rails = 6'd13;
            MODE_SERVICE: rails = 6'd29;
            default:      rails = 6'd0;
        endcase
        return rails;
    endfunction

    function automatic logic [2:0] mode_clock(input logic [2:0] mode);
        logic [2:0] prof;
        case (mode)
            MODE_LISTEN:  prof = 3'd1;
            MODE_DSP:     prof = 3'd2;
            MODE_COMMS:   prof = 3'd3;
            MODE_SERVICE: prof = 3'd4;
            default:      prof = 3'd0;
        endcase
        return prof;
    endfunction

endpackage

`default_nettype wire

// ===== src/power_mode_scheduler.sv =====
// ---------------------------------------------------------------------------
// Power mode scheduler
// Six-mode power scheduler with timeouts, global events and a ring journal.
// ---------------------------------------------------------------------------
// The scheduler takes one item per clock cycle, back to back, while o_stall
// is low, and returns exactly one result item for each: the mode after the
// item, its rail mask and clock profile, the fault code and, for journal
// reads, one journal entry. An accepted item is held in an input register;
// from there the mode logic, the timeout compares and the journal write or
// read all happen in one pass and land in the result register when it is
// free or drains, so a result is presented from the result register and is
// taken when the output is not stalled. The sustained rate of one item per
// cycle, while the output is not stalled, is set by the single pass through
// the mode logic and by the journal memory, which takes one write and one
// registered read each cycle. The result register and the input register
// keep both sides moving: a new item is taken while a finished result waits,
// and stall only reaches the input side once both registers are full.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and are only to be changed while the block holds no item.
// Journal entries are returned only after they were written, so the memory
// needs no clearing after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "power_mode_scheduler_defines.svh"

module power_mode_scheduler
    import pms_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input items
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  t_in_item                  i_data,
    // Result items
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_item                 o_data,
    // Configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    t_cfg         cfg;
    t_ctrl_status status;
    t_jrn_wr      jwr;
    logic         jrn_clear;
    t_jrn_rec     jrn_rd;
    logic         jrn_hit;
    logic [7:0]   jrn_count;

    logic         r_in_v;
    t_in_item     r_in;
    logic         r_out_v;
    t_out_item    r_out;
    t_out_item    n_out;
    logic         adv;
    logic         accept;
    logic         is_read;

    // Advance the held item whenever the result register is free or drains.
    assign adv     = r_in_v && (!r_out_v || !i_stall);
    assign o_stall = r_in_v && !adv;
    assign accept  = i_valid && !o_stall;
    assign is_read = (r_in.action == ACT_READ);

    pms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_status (status),
        .o_jwr    (jwr),
        .o_clear  (jrn_clear)
    );

    pms_journal u_journal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jwr   (jwr),
        .i_clear (jrn_clear),
        .i_rd_en (adv && is_read),
        .i_keep  (r_in.read_keep),
        .i_idx   (r_in.read_index),
        .o_rd    (jrn_rd),
        .o_hit   (jrn_hit),
        .o_count (jrn_count)
    );

    // Build the result; journal entry fields come from the registered memory read
    // port, loaded together with the result register, and are merged at the output.
    always_comb begin
        n_out               = '0;
        n_out.changed       = status.changed;
        n_out.mode_now      = status.mode;
        n_out.rails         = mode_rails(status.mode);
        n_out.clock_profile = mode_clock(status.mode);
        n_out.fault_status  = status.fault;
        n_out.read_valid    = is_read && jrn_hit;
        n_out.entry_count   = is_read ? jrn_count : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_v <= i_valid;
            end
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Hold payloads while stalled; load only on a transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_data = r_out;
        if (r_out.read_valid) begin
            o_data.entry_time  = jrn_rd.stamp;
            o_data.entry_from  = jrn_rd.from_mode;
            o_data.entry_to    = jrn_rd.to_mode;
            o_data.entry_event = jrn_rd.cause;
        end else begin
            o_data.entry_time  = 32'd0;
            o_data.entry_from  = 3'd0;
            o_data.entry_to    = 3'd0;
            o_data.entry_event = 4'd0;
        end
    end

    assign o_valid = r_out_v;

    // An accepted item always occupies the input register next cycle.
    `PMS_ASSERT_NXT(a_accept_loads, accept, r_in_v, "accepted item not held")
    // The journal never reports more entries than it can hold.
    `PMS_ASSERT_IMP(a_count_bound, o_valid, o_data.entry_count <= JOURNAL_DEPTH,
        "journal count beyond depth")
    // A mode transition and a journal hit never come from the same item.
    `PMS_ASSERT_IMP(a_change_no_read, o_valid && o_data.changed, !o_data.read_valid,
        "transition reported on a journal read")

endmodule

`default_nettype wire

// ===== src/pms_cfg.sv =====
// ---------------------------------------------------------------------------
// Power mode scheduler configuration registers
// Timeout limits and boot session flag, written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_cfg
    import pms_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [CFG_IDX_W-1:0] i_idx,
    input  wire logic [31:0]          i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_dwell     <= RST_LISTEN_DWELL;
            r_cfg.dsp_limit        <= RST_DSP_LIMIT;
            r_cfg.comms_limit      <= RST_COMMS_LIMIT;
            r_cfg.heartbeat_period <= RST_HEARTBEAT;
            r_cfg.service_window   <= RST_SVC_WINDOW;
            r_cfg.min_sleep        <= RST_MIN_SLEEP;
            r_cfg.boot_comms       <= RST_BOOT_COMMS;
        end else if (i_we) begin
            case (i_idx)
                CFG_LISTEN_DWELL: r_cfg.listen_dwell     <= i_data;
                CFG_DSP_LIMIT:    r_cfg.dsp_limit        <= i_data;
                CFG_COMMS_LIMIT:  r_cfg.comms_limit      <= i_data;
                CFG_HEARTBEAT:    r_cfg.heartbeat_period <= i_data;
                CFG_SVC_WINDOW:   r_cfg.service_window   <= i_data;
                CFG_MIN_SLEEP:    r_cfg.min_sleep        <= i_data;
                CFG_BOOT_COMMS:   r_cfg.boot_comms       <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/pms_ctrl.sv =====
// ---------------------------------------------------------------------------
// Power mode scheduler control
// Mode state, timers and flags; decides one transition per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl
    import pms_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_ctrl_status o_status,
    output t_jrn_wr   o_jwr,
    output logic      o_clear
);

    logic [2:0]  r_mode,    n_mode;
    logic [31:0] r_entered, n_entered;
    logic [31:0] r_last,    n_last;
    logic        r_cw,      n_cw;
    logic        r_outbox,  n_outbox;
    logic [1:0]  r_fault,   n_fault;

    logic        go;
    logic [2:0]  to_mode;
    logic [3:0]  cause;
    logic [31:0] dt;
    logic [31:0] dtc;
    logic        tick_conv;
    logic        run_ev;
    logic [3:0]  ev_eff;
    logic        restart;

    assign dt  = i_item.now_time - r_entered;
    assign dtc = i_item.now_time - r_last;

    // Listen and service timeouts act as their exit events.
    assign tick_conv = ((r_mode == MODE_LISTEN)  && (dt >= i_cfg.listen_dwell)) ||
                       ((r_mode == MODE_SERVICE) && (dt >= i_cfg.service_window));
    assign run_ev  = (i_item.action == ACT_EVENT) ||
                     ((i_item.action == ACT_TICK) && tick_conv);
    assign ev_eff  = (i_item.action == ACT_EVENT) ? i_item.event_code :
                     ((r_mode == MODE_LISTEN) ? EV_GATE_NEG : EV_SVC_EXIT);
    assign restart = (i_item.action == ACT_RESTART);

    always_comb begin
        n_mode    = r_mode;
        n_entered = r_entered;
        n_last    = r_last;
        n_cw      = r_cw;
        n_outbox  = r_outbox;
        n_fault   = r_fault;
        go        = 1'b0;
        to_mode   = r_mode;
        cause     = ev_eff;

        if (restart) begin
            n_mode    = MODE_SLEEP;
            n_entered = i_item.now_time;
            n_last    = i_item.now_time;
            n_cw      = 1'b0;
            n_outbox  = 1'b0;
            n_fault   = FAULT_NONE;
        end else if ((i_item.action == ACT_TICK) && !tick_conv) begin
            cause = EV_NONE;
            case (r_mode)
                MODE_SLEEP: begin
                    if (dtc >= i_cfg.heartbeat_period) begin
                        go      = 1'b1;
                        to_mode = MODE_COMMS;
                    end
                end
                MODE_DSP: begin
                    if (dt >= i_cfg.dsp_limit) begin
                        n_fault = FAULT_OVERRUN;
                        go      = 1'b1;
                        to_mode = MODE_LISTEN;
                    end
                end
                MODE_COMMS: begin
                    if (dt >= i_cfg.comms_limit) begin
                        n_last  = i_item.now_time;
                        go      = 1'b1;
                        to_mode = MODE_LISTEN;
                    end
                end
                default: ;
            endcase
        end else if (run_ev && (r_mode != MODE_SHUTDOWN)) begin
            case (ev_eff)
                EV_BATT_CRIT, EV_FAULT: begin
                    if ((ev_eff == EV_FAULT) && (r_fault == FAULT_NONE)) begin
                        n_fault = FAULT_EXT;
                    end
                    go      = 1'b1;
                    to_mode = MODE_SHUTDOWN;
                end
                EV_SVC_BTN: begin
                    if (r_mode != MODE_SERVICE) begin
                        go      = 1'b1;
                        to_mode = MODE_SERVICE;
                    end
                end
                EV_OUTBOX: begin
                    n_outbox = 1'b1;
                    n_cw     = 1'b1;
                    if ((r_mode == MODE_SLEEP) || (r_mode == MODE_LISTEN)) begin
                        go      = 1'b1;
                        to_mode = MODE_COMMS;
                    end
                end
                default: begin
                    case (r_mode)
                        MODE_SLEEP: begin
                            if (ev_eff == EV_BOOT) begin
                                go      = 1'b1;
                                to_mode = MODE_LISTEN;
                                n_cw    = i_cfg.boot_comms;
                            end else if ((ev_eff == EV_MIC) && (dt >= i_cfg.min_sleep)) begin
                                go      = 1'b1;
                                to_mode = MODE_LISTEN;
                            end
                        end
                        MODE_LISTEN: begin
                            if (ev_eff == EV_GATE_POS) begin
                                go      = 1'b1;
                                to_mode = MODE_DSP;
                            end else if (ev_eff == EV_GATE_NEG) begin
                                go      = 1'b1;
                                to_mode = r_cw ? MODE_COMMS : MODE_SLEEP;
                            end
                        end
                        MODE_DSP: begin
                            if (ev_eff == EV_DSP_EVT) begin
                                n_outbox = 1'b1;
                                go       = 1'b1;
                                to_mode  = MODE_COMMS;
                            end else if (ev_eff == EV_DSP_NONE) begin
                                go      = 1'b1;
                                to_mode = r_cw ? MODE_COMMS : MODE_LISTEN;
                            end
                        end
                        MODE_COMMS: begin
                            if (ev_eff == EV_COMMS_DONE) begin
                                n_outbox = 1'b0;
                                n_last   = i_item.now_time;
                                go       = 1'b1;
                                to_mode  = MODE_LISTEN;
                            end
                        end
                        MODE_SERVICE: begin
                            if (ev_eff == EV_SVC_EXIT) begin
                                go      = 1'b1;
                                to_mode = r_outbox ? MODE_COMMS : MODE_LISTEN;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
        end

        // Entering comms always drops the pending request.
        if (go) begin
            n_mode    = to_mode;
            n_entered = i_item.now_time;
            if (to_mode == MODE_COMMS) begin
                n_cw = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SLEEP;
            r_entered <= 32'd0;
            r_last    <= 32'd0;
            r_cw      <= 1'b0;
            r_outbox  <= 1'b0;
            r_fault   <= FAULT_NONE;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_entered <= n_entered;
            r_last    <= n_last;
            r_cw      <= n_cw;
            r_outbox  <= n_outbox;
            r_fault   <= n_fault;
        end
    end

    assign o_status.changed    = go;
    assign o_status.mode       = n_mode;
    assign o_status.fault      = n_fault;
    assign o_jwr.en            = i_fire && go;
    assign o_jwr.rec.stamp     = i_item.now_time;
    assign o_jwr.rec.from_mode = r_mode;
    assign o_jwr.rec.to_mode   = to_mode;
    assign o_jwr.rec.cause     = cause;
    assign o_clear             = i_fire && restart;

endmodule

`default_nettype wire

// ===== src/pms_journal.sv =====
// ---------------------------------------------------------------------------
// Power mode scheduler journal
// Ring memory of transitions with head pointer and fill count; one write
// and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_journal
    import pms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_jrn_wr         i_jwr,
    input  wire logic       i_clear,
    input  wire logic       i_rd_en,
    input  wire logic [7:0] i_keep,
    input  wire logic [7:0] i_idx,
    output t_jrn_rec        o_rd,
    output logic            o_hit,
    output logic [7:0]      o_count
);

    t_jrn_rec              mem [JOURNAL_DEPTH];
    t_jrn_rec              r_rd;
    logic [JRN_IW-1:0]     r_head;
    logic [JRN_FW-1:0]     r_fill;
    logic [7:0]            fill8;
    logic [7:0]            cnt;
    logic [JRN_SW-1:0]     sum;
    logic [JRN_SW-1:0]     wrapped;
    logic [JRN_IW-1:0]     rd_addr;

    assign fill8   = 8'(r_fill);
    assign cnt     = (fill8 < i_keep) ? fill8 : i_keep;
    assign o_count = cnt;
    assign o_hit   = (i_idx < cnt);

    // Oldest considered entry sits cnt places behind head; for a hit sum stays below
    // twice the depth, so one conditional subtract wraps it.
    assign sum     = JRN_SW'(r_head) + JRN_SW'(JOURNAL_DEPTH) - JRN_SW'(cnt)
                     + JRN_SW'(i_idx);
    assign wrapped = (sum >= JRN_SW'(JOURNAL_DEPTH)) ? (sum - JRN_SW'(JOURNAL_DEPTH)) : sum;
    assign rd_addr = wrapped[JRN_IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_clear) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_jwr.en) begin
            r_head <= (r_head == JRN_IW'(JOURNAL_DEPTH - 1)) ? '0 : (r_head + 1'b1);
            if (r_fill != JRN_FW'(JOURNAL_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_jwr.en) begin
            mem[r_head] <= i_jwr.rec;
        end
        if (i_rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire
